// ===== rtl/pdwls_pkg.sv =====
// shared types and constants for the pwm divider, wrap and level selection block
// no dependencies; imported by the top level and its checker
package pdwls_pkg;

	localparam int unsigned MAX_DIVIDER = 256;
	localparam int unsigned MAX_WRAP    = 65535;

	localparam int unsigned CLK_W   = 32;
	localparam int unsigned FREQ_W  = 28;
	localparam int unsigned DUTY_W  = 17;
	localparam int unsigned WRAP_W  = 16;
	localparam int unsigned DIV_W   = $clog2(MAX_DIVIDER + 1);
	localparam int unsigned RATE_W  = FREQ_W + 1;
	localparam int unsigned DVSR_W  = RATE_W + $clog2(MAX_DIVIDER);
	localparam int unsigned REM_W   = DVSR_W + 1;
	localparam int unsigned CNT_W   = $clog2(CLK_W);
	localparam int unsigned PROD_W  = WRAP_W + DUTY_W;

	localparam logic [DUTY_W-1:0] DUTY_ONE = DUTY_W'(65536);

	typedef enum logic [1:0] {
		ST_FIT   = 2'd0,
		ST_NOFIT = 2'd1,
		ST_ZERO  = 2'd2
	} status_t;

	typedef enum logic {
		CFG_CLOCK_HZ   = 1'b0,
		CFG_DUAL_SLOPE = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_CHECK,
		S_LEVEL,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [FREQ_W-1:0] frequency_hz;
		logic [DUTY_W-1:0] duty_fraction;
	} in_word_t;

	typedef struct packed {
		logic [WRAP_W-1:0] wrap_value;
		logic [DIV_W-1:0]  clock_divider;
		logic [WRAP_W-1:0] compare_level;
		status_t           status;
	} out_word_t;

endpackage

// ===== rtl/pwm_divider_wrap_and_level_select.sv =====
// pwm divider, wrap and compare level selection, top level
// depends on pdwls_pkg
// sequence: for each divider tried, 32 restoring steps and a check, then the level multiply
//   and the output load; a zero frequency skips the search and goes straight to the level step
// flow: one word at a time; the shared 32-step divider sets the pace, and a new word is
//   taken the cycle after the previous result is loaded
// reset: arst_n clears the sequencer and the output valid, and loads clock_hz 125000000, dual_slope 0
module pwm_divider_wrap_and_level_select
	import pdwls_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	// input words
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	// result words
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word,
	// register writes
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  cfg_idx_t  cfg_index,
	input  logic [CLK_W-1:0] cfg_data
);

	state_t state_q, state_d;

	// configuration registers
	logic [CLK_W-1:0] clock_hz_q;
	logic             dual_slope_q;

	// search datapath
	logic [RATE_W-1:0] rate_q;      // wanted rate, doubled for dual slope
	logic [DVSR_W-1:0] dvsr_q;      // trial divider times rate, built by repeated add
	logic [DIV_W-1:0]  trial_q;     // divider under test
	logic [REM_W-1:0]  rem_q;       // partial remainder
	logic [CLK_W-1:0]  quo_q;       // dividend shifts out, quotient shifts in
	logic [CNT_W-1:0]  cnt_q;
	logic [DUTY_W-1:0] duty_q;
	logic [WRAP_W-1:0] wrap_q;
	logic [DIV_W-1:0]  div_q;
	status_t           status_q;
	logic [WRAP_W-1:0] level_q;

	out_word_t out_q;
	logic      out_valid_q;

	logic in_take;
	logic out_load;

	// restoring step
	logic [REM_W-1:0] rem_sh;
	logic             rem_ge;
	logic [REM_W-1:0] rem_nx;

	// fit test on the finished quotient: 1 <= q <= MAX_WRAP+1
	logic fit;
	logic last_trial;
	logic last_step;

	logic [PROD_W-1:0] prod;

	assign cfg_ready = 1'b1;

	assign rem_sh = {rem_q[REM_W-2:0], quo_q[CLK_W-1]};
	assign rem_ge = rem_sh >= {1'b0, dvsr_q};
	assign rem_nx = rem_ge ? (rem_sh - {1'b0, dvsr_q}) : rem_sh;

	assign fit        = (quo_q != '0) && ({1'b0, quo_q} <= (CLK_W+1)'(MAX_WRAP + 1));
	assign last_trial = trial_q == DIV_W'(MAX_DIVIDER);
	assign last_step  = cnt_q == CNT_W'(CLK_W - 1);

	assign prod = wrap_q * duty_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (in_word.frequency_hz == '0) ? S_LEVEL : S_DIV;
				end
			end
			S_DIV: begin
				if (last_step) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = (fit || last_trial) ? S_LEVEL : S_DIV;
			end
			S_LEVEL: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
			end
			S_OUT: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q   <= CLK_W'(125000000);
			dual_slope_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CLOCK_HZ:   clock_hz_q   <= cfg_data;
				CFG_DUAL_SLOPE: dual_slope_q <= cfg_data[0];
				default:        clock_hz_q   <= clock_hz_q;
			endcase
		end
	end

	// search datapath, one restoring step per cycle
	always_ff @(posedge clk) begin
		if (in_take) begin
			// saturate duty above one
			duty_q   <= (in_word.duty_fraction > DUTY_ONE) ? DUTY_ONE : in_word.duty_fraction;
			rate_q   <= dual_slope_q ? {in_word.frequency_hz, 1'b0}
			                         : {1'b0, in_word.frequency_hz};
			dvsr_q   <= DVSR_W'(dual_slope_q ? {in_word.frequency_hz, 1'b0}
			                                 : {1'b0, in_word.frequency_hz});
			trial_q  <= DIV_W'(1);
			rem_q    <= '0;
			quo_q    <= clock_hz_q;
			cnt_q    <= '0;
			// zero frequency result, kept if the search is skipped
			wrap_q   <= '0;
			div_q    <= DIV_W'(1);
			status_q <= ST_ZERO;
		end else if (state_q == S_DIV) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[CLK_W-2:0], rem_ge};
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (state_q == S_CHECK) begin
			if (fit) begin
				wrap_q   <= WRAP_W'(quo_q - CLK_W'(1));
				div_q    <= trial_q;
				status_q <= ST_FIT;
			end else if (last_trial) begin
				wrap_q   <= WRAP_W'(MAX_WRAP);
				div_q    <= DIV_W'(MAX_DIVIDER);
				status_q <= ST_NOFIT;
			end else begin
				trial_q <= trial_q + DIV_W'(1);
				dvsr_q  <= dvsr_q + DVSR_W'(rate_q);
				rem_q   <= '0;
				quo_q   <= clock_hz_q;
				cnt_q   <= '0;
			end
		end else if (state_q == S_LEVEL) begin
			// wrap times duty, truncated
			level_q <= prod[WRAP_W+15:16];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.wrap_value    <= wrap_q;
			out_q.clock_divider <= div_q;
			out_q.compare_level <= level_q;
			out_q.status        <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

// ===== rtl/pdwls_checker.sv =====
// port-level checks for the pwm divider, wrap and level selection block
// depends on pdwls_pkg; bound to the top level below
module pdwls_checker
	import pdwls_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_word_t  in_word,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_word
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed under stall");

	// busy in the cycle after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a search runs");

	// level never above wrap
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.compare_level <= out_word.wrap_value)
		else $error("compare level above wrap");

	// divider in range, and at its maximum when nothing fits
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.clock_divider != '0
			&& out_word.clock_divider <= DIV_W'(MAX_DIVIDER)
			&& (out_word.status != ST_NOFIT
				|| (out_word.clock_divider == DIV_W'(MAX_DIVIDER)
				&& out_word.wrap_value == WRAP_W'(MAX_WRAP))))
		else $error("divider out of range");

	// zero frequency gives fixed fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == ST_ZERO |-> out_word.wrap_value == '0
			&& out_word.compare_level == '0 && out_word.clock_divider == DIV_W'(1))
		else $error("zero frequency result wrong");

endmodule

bind pwm_divider_wrap_and_level_select pdwls_checker u_pdwls_checker (.*);

// ===== dv/tb_pwm_divider_wrap_and_level_select.sv =====
// self-checking testbench for the pwm divider, wrap and compare level selection block
// depends on pdwls_pkg and the rtl top level; a scoreboard class predicts each result word
`timescale 1ns / 100ps

module tb_pwm_divider_wrap_and_level_select;
	import pdwls_pkg::*;

	// scoreboard: keeps its own copy of the registers and a queue of predicted settings
	class pwm_setting_board;
		logic [CLK_W-1:0] clock_hz;
		logic             dual_slope;
		out_word_t        pending_settings[$];
		int unsigned      mismatches;
		int unsigned      results_seen;

		function new();
			clock_hz     = 125000000;
			dual_slope   = 1'b0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_register(cfg_idx_t idx, logic [CLK_W-1:0] data);
			case (idx)
				CFG_CLOCK_HZ:   clock_hz = data;
				CFG_DUAL_SLOPE: dual_slope = data[0];
				default:        ;
			endcase
		endfunction

		// smallest divider whose wrap fits, then the duty-scaled compare level
		function out_word_t predict_setting(in_word_t w);
			logic [63:0] freq;
			logic [63:0] duty;
			logic [63:0] rate;
			logic [63:0] quot;
			logic [63:0] wrap;
			logic [63:0] divv;
			logic [63:0] lvl;
			bit          found;
			out_word_t   r;
			freq            = 64'(w.frequency_hz);
			duty            = 64'(w.duty_fraction);
			r.wrap_value    = '0;
			r.clock_divider = DIV_W'(1);
			r.compare_level = '0;
			r.status        = ST_FIT;
			if (duty > 64'(DUTY_ONE))
				duty = 64'(DUTY_ONE);
			if (freq == 0) begin
				r.status = ST_ZERO;
				return r;
			end
			rate  = dual_slope ? (freq << 1) : freq;
			found = 1'b0;
			wrap  = 64'(MAX_WRAP);
			divv  = 64'(MAX_DIVIDER);
			for (int unsigned d = 1; d <= MAX_DIVIDER; d++) begin
				if (!found) begin
					quot = 64'(clock_hz) / (64'(d) * rate);
					// a zero quotient would give a negative wrap, so keep looking
					if (quot != 0 && (quot - 1) <= 64'(MAX_WRAP)) begin
						found = 1'b1;
						wrap  = quot - 1;
						divv  = 64'(d);
					end
				end
			end
			lvl             = (wrap * duty) >> 16;
			r.wrap_value    = WRAP_W'(wrap);
			r.clock_divider = DIV_W'(divv);
			r.compare_level = WRAP_W'(lvl);
			r.status        = found ? ST_FIT : ST_NOFIT;
			return r;
		endfunction

		function void note_request(in_word_t w);
			pending_settings.push_back(predict_setting(w));
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			end
		endfunction

		function void check_setting(out_word_t got);
			out_word_t want;
			results_seen++;
			if (pending_settings.size() == 0) begin
				mismatches++;
				$display("%0t: result word with nothing expected, expected none got %h",
					$time, got);
				return;
			end
			want = pending_settings.pop_front();
			compare_field("wrap_value", want.wrap_value, got.wrap_value);
			compare_field("clock_divider", want.clock_divider, got.clock_divider);
			compare_field("compare_level", want.compare_level, got.compare_level);
			compare_field("status", want.status, got.status);
		endfunction

		function int unsigned outstanding();
			return pending_settings.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_word_t         in_word;
	logic             out_valid;
	logic             out_stall;
	out_word_t        out_word;
	logic             cfg_valid;
	logic             cfg_ready;
	cfg_idx_t         cfg_index;
	logic [CLK_W-1:0] cfg_data;

	pwm_setting_board sb = new();

	// sender and receiver pacing, each variable written by one process only
	int unsigned rx_mode;
	bit          tx_idle;
	int unsigned burst_left;
	int unsigned rx_tick;
	int unsigned hold_left;
	bit          hold_done;

	// directed words: zero frequency, zero quotient, no fit, exact edges of the d=1 fit,
	// large divider and every duty corner including values above one
	logic [FREQ_W-1:0] dir_freq [0:12] = '{
		28'd0, 28'd0, 28'd1, 28'hFFFFFFF, 28'd1908, 28'd1907, 28'd62500000,
		28'd125000000, 28'd125000001, 28'd8, 28'd7, 28'd2, 28'd1000
	};
	logic [DUTY_W-1:0] dir_duty [0:12] = '{
		17'd0, 17'h1FFFF, 17'd65536, 17'd65535, 17'd32768, 17'd1, 17'd65535,
		17'd65537, 17'd0, 17'd65536, 17'h1FFFF, 17'd12345, 17'd98304
	};

	pwm_divider_wrap_and_level_select u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// both channels sampled at the rising edge; inputs only move at the falling edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(in_word);
			if (out_valid && !out_stall)
				sb.check_setting(out_word);
		end
	end

	// frequency mix: mostly rates that fit with a small divider, plus zero, full-range
	// noise (mostly zero quotient) and very low rates that need a big divider or none
	function automatic logic [FREQ_W-1:0] pick_frequency();
		logic [63:0] span;
		logic [63:0] f;
		int unsigned mode;
		mode = $urandom_range(0, 19);
		case (mode)
			0: f = 64'd0;
			1: f = 64'($urandom & 32'h0FFFFFFF);
			2: f = 64'($urandom_range(1, 64));
			default: begin
				span = 64'(sb.dual_slope ? 2 : 1) * 64'($urandom_range(1, 4))
					* 64'($urandom_range(0, 1) ? $urandom_range(1, 65536)
					: $urandom_range(1, 300));
				f = 64'(sb.clock_hz) / span;
				if (f == 0)
					f = 64'd1;
				if (f > 64'h0FFFFFFF)
					f = 64'h0FFFFFFF;
			end
		endcase
		return FREQ_W'(f);
	endfunction

	function automatic logic [DUTY_W-1:0] pick_duty();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return DUTY_ONE;
			2:       return DUTY_W'(65535);
			3:       return DUTY_W'($urandom_range(65537, 131071));
			default: return DUTY_W'($urandom);
		endcase
	endfunction

	// entered at a falling edge; leaves valid high so a burst runs back to back
	task automatic send_word(input in_word_t w);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			if (tx_idle)
				gap = $urandom_range(1, 12);
		end
		burst_left--;
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_word  = w;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random(input int unsigned n);
		in_word_t w;
		repeat (n) begin
			w.frequency_hz  = pick_frequency();
			w.duty_fraction = pick_duty();
			send_word(w);
		end
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CLK_W-1:0] data);
		cfg_index = idx;
		cfg_data  = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// registers only change once every result word of the last phase is back
	task automatic run_phase(input logic [CLK_W-1:0] clock_hz, input logic dual,
		input int unsigned n, input int unsigned rxm, input bit idle);
		wait_drained();
		write_reg(CFG_CLOCK_HZ, clock_hz);
		write_reg(CFG_DUAL_SLOPE, CLK_W'(dual));
		rx_mode = rxm;
		tx_idle = idle;
		send_random(n);
	endtask

	// receiver: its own stall pattern, and one long hold-off so the block backs up
	initial begin
		out_stall = 1'b0;
		rx_tick   = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			rx_tick++;
			if (!hold_done && sb.results_seen >= 12) begin
				hold_left = 3000;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				case (rx_mode)
					0:       out_stall = 1'b0;
					1:       out_stall = ($urandom_range(0, 3) == 0);
					default: out_stall = ((rx_tick % 7) < 3);
				endcase
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_word    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_CLOCK_HZ;
		cfg_data   = '0;
		rx_mode    = 1;
		tx_idle    = 1'b1;
		burst_left = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words at the reset settings
		for (int i = 0; i < 13; i++)
			send_word('{frequency_hz: dir_freq[i], duty_fraction: dir_duty[i]});
		in_valid = 1'b0;
		send_random(30);

		// top clock with phase-correct counting, then the slowest clock (only 1 Hz fits),
		// then two ordinary settings with and without idling
		run_phase(32'hFFFFFFFF, 1'b1, 25, 2, 1'b1);
		run_phase(32'd1, 1'b0, 4, 0, 1'b0);
		run_phase(32'd48000000, 1'b1, 25, 1, 1'b0);
		run_phase(32'd125000000, 1'b0, 20, 1, 1'b1);

		wait_drained();
		// room for any stray word after the last one expected
		repeat (9000) @(negedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#50000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
